// ===== design/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/i128alu_pkg.sv =====
package i128alu_pkg;

  typedef enum logic [3:0] {
    KIND_ADD = 4'd0,
    KIND_SUB = 4'd1,
    KIND_MUL = 4'd2,
    KIND_DIV = 4'd3,
    KIND_AND = 4'd4,
    KIND_OR  = 4'd5,
    KIND_XOR = 4'd6,
    KIND_NOT = 4'd7,
    KIND_SHL = 4'd8,
    KIND_SHR = 4'd9
  } kind_t;

  localparam int MAX_BITS = 128;
  localparam int HALF_BITS = 64;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  neg;
    logic  dz;
  } ctrl_t;

endpackage

// ===== design/int128_alu.sv =====
// int128_alu_top: pipelined 128-bit two's complement integer alu
// input channel: in_valid / in_stall with kind, a_hi/a_lo, b_hi/b_lo, shift_amount
// output channel: out_valid / out_stall with result_hi/result_lo and div_by_zero
// ops: add, sub, signed mul, signed div (truncating), and, or, xor, not, shl, shr
// results wrap modulo 2^W, W = WORD_BITS capped at 128; upper result bits are zero
// the pipeline is one prep stage, W cells and one output stage
// throughput is one transfer per cycle: every cell does one restoring divide step
// and one shift-add multiply step, so a new item enters each cycle unless out_stall holds
// a pending result; a zero divisor returns all ones and raises div_by_zero
// when out_stall holds a pending result the whole chain freezes and in_stall rises
// in the same cycle; nothing is dropped and the held result stays on the ports
// reset clears the valid bits of every stage; no data is cleared
module int128_alu_top
  import i128alu_pkg::*;
#(
  parameter int WORD_BITS = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           kind,
  input  logic [HALF_BITS-1:0] a_hi,
  input  logic [HALF_BITS-1:0] a_lo,
  input  logic [HALF_BITS-1:0] b_hi,
  input  logic [HALF_BITS-1:0] b_lo,
  input  logic [7:0]           shift_amount,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [HALF_BITS-1:0] result_hi,
  output logic [HALF_BITS-1:0] result_lo,
  output logic                 div_by_zero
);

  localparam int W = (WORD_BITS > MAX_BITS) ? MAX_BITS : WORD_BITS;

  logic         en;
  ctrl_t        ctrl_c [0:W];
  logic [W-1:0] num_c [0:W];
  logic [W-1:0] rem_c [0:W];
  logic [W-1:0] d_c   [0:W];
  logic [W-1:0] ma_c  [0:W];
  logic [W-1:0] mb_c  [0:W];
  logic [W-1:0] acc_c [0:W];
  logic [W-1:0] res_c [0:W];

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;
  assign rem_c[0] = '0;
  assign acc_c[0] = '0;

  i128alu_prep #(.W(W)) u_prep (
    .clk, .rst, .en, .in_valid, .kind, .a_hi, .a_lo, .b_hi, .b_lo, .shift_amount,
    .ctrl(ctrl_c[0]), .num(num_c[0]), .d(d_c[0]), .ma(ma_c[0]), .mb(mb_c[0]),
    .res(res_c[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_cell
    i128alu_cell #(.W(W)) u_cell (
      .clk, .rst, .en,
      .ctrl_in(ctrl_c[i]), .num_in(num_c[i]), .rem_in(rem_c[i]), .d_in(d_c[i]),
      .ma_in(ma_c[i]), .mb_in(mb_c[i]), .acc_in(acc_c[i]), .res_in(res_c[i]),
      .ctrl_out(ctrl_c[i+1]), .num_out(num_c[i+1]), .rem_out(rem_c[i+1]),
      .d_out(d_c[i+1]), .ma_out(ma_c[i+1]), .mb_out(mb_c[i+1]),
      .acc_out(acc_c[i+1]), .res_out(res_c[i+1])
    );
  end

  i128alu_fin #(.W(W)) u_fin (
    .clk, .rst, .en, .ctrl(ctrl_c[W]), .quo(num_c[W]), .acc(acc_c[W]), .res(res_c[W]),
    .out_valid, .result_hi, .result_lo, .div_by_zero
  );

endmodule

// ===== design/i128alu_prep.sv =====
module i128alu_prep
  import i128alu_pkg::*;
#(
  parameter int W = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [3:0]           kind,
  input  logic [HALF_BITS-1:0] a_hi,
  input  logic [HALF_BITS-1:0] a_lo,
  input  logic [HALF_BITS-1:0] b_hi,
  input  logic [HALF_BITS-1:0] b_lo,
  input  logic [7:0]           shift_amount,
  output ctrl_t                ctrl,
  output logic [W-1:0]         num,
  output logic [W-1:0]         d,
  output logic [W-1:0]         ma,
  output logic [W-1:0]         mb,
  output logic [W-1:0]         res
);

  logic [MAX_BITS-1:0] a_full, b_full;
  logic [W-1:0]        a, b, a_mag, b_mag, sum, b_op, res_next;
  logic                sa, sb, is_sub;
  kind_t               k;
  ctrl_t               ctrl_next;

  always_comb begin
    a_full = {a_hi, a_lo};
    b_full = {b_hi, b_lo};
    a = a_full[W-1:0];
    b = b_full[W-1:0];
    sa = a[W-1];
    sb = b[W-1];
    a_mag = sa ? (~a + W'(1)) : a;
    b_mag = sb ? (~b + W'(1)) : b;
    k = kind_t'(kind);
    is_sub = (k == KIND_SUB);
    b_op = is_sub ? ~b : b;
    sum = a + b_op + W'(is_sub);
    unique case (k)
      KIND_ADD, KIND_SUB: res_next = sum;
      KIND_AND:           res_next = a & b;
      KIND_OR:            res_next = a | b;
      KIND_XOR:           res_next = a ^ b;
      KIND_NOT:           res_next = ~a;
      KIND_SHL:           res_next = (32'(shift_amount) >= W) ? '0 : (a << shift_amount);
      KIND_SHR:           res_next = (32'(shift_amount) >= W) ? '0 : (a >> shift_amount);
      default:            res_next = '0;
    endcase
    ctrl_next.valid = in_valid;
    ctrl_next.kind  = k;
    ctrl_next.neg   = sa ^ sb;
    ctrl_next.dz    = (k == KIND_DIV) && (b == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= ctrl_next.valid;
    end
    if (en) begin
      ctrl.kind <= ctrl_next.kind;
      ctrl.neg  <= ctrl_next.neg;
      ctrl.dz   <= ctrl_next.dz;
      num <= a_mag;
      d   <= b_mag;
      ma  <= a_mag;
      mb  <= b_mag;
      res <= res_next;
    end
  end

endmodule

// ===== design/i128alu_cell.sv =====
`include "assert_macros.svh"

module i128alu_cell
  import i128alu_pkg::*;
#(
  parameter int W = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  ctrl_t        ctrl_in,
  input  logic [W-1:0] num_in,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] d_in,
  input  logic [W-1:0] ma_in,
  input  logic [W-1:0] mb_in,
  input  logic [W-1:0] acc_in,
  input  logic [W-1:0] res_in,
  output ctrl_t        ctrl_out,
  output logic [W-1:0] num_out,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] d_out,
  output logic [W-1:0] ma_out,
  output logic [W-1:0] mb_out,
  output logic [W-1:0] acc_out,
  output logic [W-1:0] res_out
);

  logic [W:0]   r2, dx, diff;
  logic         ge;
  logic [W-1:0] rem_next, num_next, acc_next;

  // one restoring divide step and one shift-add multiply step
  always_comb begin
    r2 = {rem_in, num_in[W-1]};
    dx = {1'b0, d_in};
    diff = r2 - dx;
    ge = (r2 >= dx);
    rem_next = ge ? diff[W-1:0] : r2[W-1:0];
    num_next = {num_in[W-2:0], ge};
    acc_next = acc_in + (mb_in[0] ? ma_in : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    if (en) begin
      ctrl_out.kind <= ctrl_in.kind;
      ctrl_out.neg  <= ctrl_in.neg;
      ctrl_out.dz   <= ctrl_in.dz;
      num_out <= num_next;
      rem_out <= rem_next;
      d_out   <= d_in;
      ma_out  <= ma_in << 1;
      mb_out  <= mb_in >> 1;
      acc_out <= acc_next;
      res_out <= res_in;
    end
  end

  `ASSERT_NEXT(a_rem_below_div,
    en && ctrl_in.valid && ctrl_in.kind == KIND_DIV && !ctrl_in.dz && rem_in < d_in,
    rem_out < d_out)
  `ASSERT_NEXT(a_dz_follows,
    en && ctrl_in.valid, ctrl_out.valid && ctrl_out.dz == $past(ctrl_in.dz))

endmodule

// ===== design/i128alu_fin.sv =====
`include "assert_macros.svh"

module i128alu_fin
  import i128alu_pkg::*;
#(
  parameter int W = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctrl_t                ctrl,
  input  logic [W-1:0]         quo,
  input  logic [W-1:0]         acc,
  input  logic [W-1:0]         res,
  output logic                 out_valid,
  output logic [HALF_BITS-1:0] result_hi,
  output logic [HALF_BITS-1:0] result_lo,
  output logic                 div_by_zero
);

  logic [W-1:0]        sel, val;
  logic [MAX_BITS-1:0] wide;

  always_comb begin
    case (ctrl.kind)
      KIND_DIV: sel = quo;
      KIND_MUL: sel = acc;
      default:  sel = res;
    endcase
    if (ctrl.kind == KIND_DIV && ctrl.dz) begin
      val = '1;
    end else if ((ctrl.kind == KIND_DIV || ctrl.kind == KIND_MUL) && ctrl.neg) begin
      val = ~sel + W'(1);
    end else begin
      val = sel;
    end
    wide = MAX_BITS'(val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_hi   <= wide[MAX_BITS-1:HALF_BITS];
      result_lo   <= wide[HALF_BITS-1:0];
      div_by_zero <= ctrl.dz && (ctrl.kind == KIND_DIV);
    end
  end

  `ASSERT_IMPL(a_dz_ones, out_valid && div_by_zero,
    MAX_BITS'({result_hi, result_lo}) == MAX_BITS'({W{1'b1}}))
  `ASSERT_NEXT(a_hold_stalled, out_valid && !en,
    out_valid && $stable(result_hi) && $stable(result_lo) && $stable(div_by_zero))

endmodule
